[hdl/sha256_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values, the front-to-back queue entry type and
// the round helper functions shared by the hasher modules.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // One classified input transfer handed from the front part to the back part.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       final_req;
    } sha_item_t;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] h;
        unique case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage : sha256_pkg
`default_nettype wire

[hdl/sha256_hasher.sv]
`default_nettype none
// A full block is compressed one round per cycle in the shared round unit, and the core
// takes no queued bytes meanwhile. A final transfer costs one or two padded blocks and eight
// output transfers. Reset loads the initial hash values and empties the queue.
// ----------------------------------------------------------------------------
// SHA-256 hasher top level
// Byte stream in, eight digest words out; front queue and compression core.
// ----------------------------------------------------------------------------
module sha256_hasher (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tuser,   // no_byte
    input  wire logic        s_tlast,   // final_req
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // digest_word
    output logic [2:0]       m_tuser,   // word_index
    output logic             m_tlast    // last_word
);
    import sha256_pkg::*;

    sha_item_t in_item, q_item;
    logic      q_valid, q_ready;

    assign in_item.data_byte = s_tdata;
    assign in_item.has_byte  = ~s_tuser;
    assign in_item.final_req = s_tlast;

    sha256_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    sha256_core u_core (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_word(m_tdata), .out_index(m_tuser), .out_last(m_tlast)
    );

`ifndef SYNTHESIS
    // The core never takes a queued item while it is sending the digest.
    a_no_take_in_send: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !q_ready) else $error("item taken during digest output");
    // The last flag marks word seven alone.
    a_last_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == 3'd7))) else $error("last flag misplaced");
    // Word index advances by one after each output transfer before the last.
    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser == $past(m_tuser) + 3'd1))
        else $error("word index skipped");
`endif

endmodule : sha256_hasher
`default_nettype wire

[hdl/sha256_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 front part
// Accepts input transfers, drops items that carry neither a byte nor the end
// mark, and queues the rest for the compression back part.
// ----------------------------------------------------------------------------
module sha256_front (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire sha256_pkg::sha_item_t in_item,
    output logic                       q_valid,
    input  wire logic                  q_ready,
    output sha256_pkg::sha_item_t      q_item
);
    import sha256_pkg::*;

    sha_item_t             mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  push, pop;

    // Only useful items enter the queue.
    assign in_ready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready && (in_item.has_byte || in_item.final_req);
    assign q_valid  = (count_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule : sha256_front
`default_nettype wire

[hdl/sha256_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 back part
// Packs bytes into a sixteen-word schedule window, runs one round per cycle,
// pads at end of message and sends out the eight digest words.
// ----------------------------------------------------------------------------
module sha256_core (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  q_valid,
    output logic                       q_ready,
    input  wire sha256_pkg::sha_item_t q_item,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [31:0]                out_word,
    output logic [2:0]                 out_index,
    output logic                       out_last
);
    import sha256_pkg::*;

    localparam logic [2:0] ST_TAKE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_PAD   = 3'd2;
    localparam logic [2:0] ST_SEND  = 3'd3;

    logic [2:0]  state_reg, state_next;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  fill_reg;
    logic [63:0] total_reg;
    logic [5:0]  round_reg;
    logic        pad_done_reg;   // 0x80 already placed
    logic        last_blk_reg;   // length block or final full data block being compressed
    logic [2:0]  send_reg;

    logic [31:0] w_new, w_cur, t1, t2, s0, s1, ee, aa, ch, mj;
    logic [31:0] pad_word;
    logic [3:0]  wi;
    logic [1:0]  bi;

    assign wi = fill_reg[5:2];
    assign bi = fill_reg[1:0];

    // Round datapath on the schedule window head.
    always_comb begin
        w_cur = w_reg[0];
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        ee = v_reg[4];
        aa = v_reg[0];
        ch = (ee & v_reg[5]) ^ (~ee & v_reg[6]);
        mj = (aa & v_reg[1]) ^ (aa & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1 = v_reg[7] + (rotr(ee, 6) ^ rotr(ee, 11) ^ rotr(ee, 25)) + ch
             + round_k(round_reg) + w_cur;
        t2 = (rotr(aa, 2) ^ rotr(aa, 13) ^ rotr(aa, 22)) + mj;
    end

    // Partly filled word with the 0x80 marker after the last byte.
    always_comb begin
        unique case (bi)
            2'd0: pad_word = 32'h80000000;
            2'd1: pad_word = {w_reg[wi][31:24], 24'h800000};
            2'd2: pad_word = {w_reg[wi][31:16], 16'h8000};
            default: pad_word = {w_reg[wi][31:8], 8'h80};
        endcase
    end

    assign q_ready   = (state_reg == ST_TAKE);
    assign out_valid = (state_reg == ST_SEND);
    assign out_word  = h_reg[send_reg];
    assign out_index = send_reg;
    assign out_last  = (send_reg == 3'd7);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_TAKE: begin
                if (q_valid) begin
                    if (q_item.has_byte && fill_reg == 6'd63) begin
                        state_next = ST_ROUND;
                    end else if (q_item.final_req) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND: begin
                if (round_reg == 6'd63) begin
                    if (last_blk_reg && pad_done_reg)      state_next = ST_SEND;
                    else if (last_blk_reg || pad_done_reg) state_next = ST_PAD;
                    else                                   state_next = ST_TAKE;
                end
            end
            ST_PAD:   state_next = ST_ROUND;
            ST_SEND: begin
                if (out_ready && send_reg == 3'd7) state_next = ST_TAKE;
            end
            default:  state_next = ST_TAKE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_TAKE;
            fill_reg     <= '0;
            total_reg    <= '0;
            round_reg    <= '0;
            pad_done_reg <= 1'b0;
            last_blk_reg <= 1'b0;
            send_reg     <= '0;
            for (int i = 0; i < 8; i++) h_reg[i] <= init_hash(3'(i));
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_TAKE: begin
                    if (q_valid) begin
                        if (q_item.has_byte) begin
                            w_reg[wi][8*(3-bi) +: 8] <= q_item.data_byte;
                            fill_reg  <= fill_reg + 1'b1;
                            total_reg <= total_reg + 64'd1;
                        end
                        pad_done_reg <= 1'b0;
                        // Final on a full block: pad after that block.
                        if (q_item.has_byte && fill_reg == 6'd63) begin
                            last_blk_reg <= q_item.final_req;
                            round_reg    <= '0;
                            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                        end
                    end
                end
                ST_ROUND: begin
                    v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= w_new;
                    round_reg <= round_reg + 1'b1;
                    if (round_reg == 6'd63) begin
                        h_reg[0] <= h_reg[0] + t1 + t2;
                        h_reg[1] <= h_reg[1] + v_reg[0];
                        h_reg[2] <= h_reg[2] + v_reg[1];
                        h_reg[3] <= h_reg[3] + v_reg[2];
                        h_reg[4] <= h_reg[4] + v_reg[3] + t1;
                        h_reg[5] <= h_reg[5] + v_reg[4];
                        h_reg[6] <= h_reg[6] + v_reg[5];
                        h_reg[7] <= h_reg[7] + v_reg[6];
                        // A final on the 64th byte still needs a full padding block.
                        if (last_blk_reg && !pad_done_reg) begin
                            last_blk_reg <= 1'b0;
                        end
                    end
                end
                ST_PAD: begin
                    round_reg <= '0;
                    for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                    if (!pad_done_reg) begin
                        // Place 0x80, clear the rest of the block, add the length if it fits.
                        for (int i = 0; i < 16; i++) begin
                            if (4'(i) == wi) begin
                                w_reg[i] <= pad_word;
                            end else if (4'(i) > wi) begin
                                if (fill_reg <= 6'd55 && i == 14) begin
                                    w_reg[i] <= total_reg[60:29];
                                end else if (fill_reg <= 6'd55 && i == 15) begin
                                    w_reg[i] <= {total_reg[28:0], 3'b000};
                                end else begin
                                    w_reg[i] <= '0;
                                end
                            end
                        end
                        if (fill_reg <= 6'd55) begin
                            last_blk_reg <= 1'b1;
                        end else begin
                            last_blk_reg <= 1'b0;
                        end
                        pad_done_reg <= 1'b1;
                    end else begin
                        // Length-only block.
                        for (int i = 0; i < 16; i++) begin
                            if (i == 14) begin
                                w_reg[i] <= total_reg[60:29];
                            end else if (i == 15) begin
                                w_reg[i] <= {total_reg[28:0], 3'b000};
                            end else begin
                                w_reg[i] <= '0;
                            end
                        end
                        last_blk_reg <= 1'b1;
                    end
                    fill_reg <= '0;
                end
                ST_SEND: begin
                    if (out_ready) begin
                        send_reg <= send_reg + 1'b1;
                        if (send_reg == 3'd7) begin
                            for (int i = 0; i < 8; i++) h_reg[i] <= init_hash(3'(i));
                            total_reg    <= '0;
                            fill_reg     <= '0;
                            pad_done_reg <= 1'b0;
                            last_blk_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule : sha256_core
`default_nettype wire
